@@ rtl/nearest_vector_search_top_defines.svh @@
// ---------------------------------------------------------------------------
// Nearest vector search assertion macros
// Concurrent assertion wrappers clocked on i_clk.
// ---------------------------------------------------------------------------
`ifndef NEAREST_VECTOR_SEARCH_TOP_DEFINES_SVH
`define NEAREST_VECTOR_SEARCH_TOP_DEFINES_SVH

// check while out of reset
`define NVS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every edge, reset included
`define NVS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/nvs_pkg.sv @@
// ---------------------------------------------------------------------------
// Nearest vector search package
// Sizes, item kinds and pipeline control types.
// ---------------------------------------------------------------------------
package nvs_pkg;

    localparam int DIMENSIONS     = 200;
    localparam int MAX_CANDIDATES = 1024;
    localparam int THRESHOLD      = 0;

    localparam int VAL_W  = 16;
    localparam int SQ_W   = 2 * VAL_W;
    localparam int DIST_W = 40;
    localparam int IDX_W  = 10;
    localparam int POS_W  = $clog2(DIMENSIONS + 1);
    localparam int ADDR_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_CANDIDATES);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        KIND_QUERY  = 2'd0,
        KIND_CAND   = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef struct packed {
        logic fin;
        logic last;
        logic is_query;
        logic in_range;
    } t_ctl;

endpackage

@@ rtl/nearest_vector_search_top.sv @@
// ---------------------------------------------------------------------------
// Nearest vector search top level
// Squared Euclidean nearest-candidate search over streamed Q3.12 vectors.
// ---------------------------------------------------------------------------
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-----------------------------------
//  in      | i_in_valid   | o_in_ready   | kind, element_value, last_element,
//          |              |              | candidate_is_query
//  out     | o_out_valid  | i_out_ready  | best_index, best_distance, found
//
//  One input beat per cycle while o_in_ready is high; a finish beat's result
//  is offered after passing the query store read, square and
//  accumulate/compare stages into the output register.
//  Reset is synchronous and active low; no clearing pass is needed.
//  Input stalls only when a finish beat reaches the last stage while the
//  output register still holds an untaken result.
// ---------------------------------------------------------------------------
`include "nearest_vector_search_top_defines.svh"

module nearest_vector_search_top
    import nvs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_kind,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic                    i_last_element,
    input  logic                    i_candidate_is_query,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [IDX_W-1:0]        o_best_index,
    output logic [DIST_W-1:0]       o_best_distance,
    output logic                    o_found
);

    logic [VAL_W-1:0] r_query_mem [DIMENSIONS];

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              w_en, w_accept, w_in_range;
    logic [ADDR_W-1:0] w_addr;
    logic              w_is_query, w_is_cand, w_is_fin;

    logic              r1_valid;
    t_ctl              r1_ctl;
    logic [VAL_W-1:0]  r1_value;
    logic [VAL_W-1:0]  r1_qdata;

    logic signed [VAL_W:0] w_diff;
    logic [VAL_W:0]        w_mag;
    logic [SQ_W-1:0]       w_sq;

    logic              r2_valid;
    t_ctl              r2_ctl;
    logic [SQ_W-1:0]   r2_sq;

    logic [DIST_W-1:0] r_acc, n_acc;
    logic [DIST_W:0]   w_sum;
    logic [DIST_W-1:0] w_acc_new;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_best_idx, n_best_idx;
    logic [DIST_W-1:0] r_best_dist, n_best_dist;
    logic              r_found, n_found;
    logic              w_take;
    logic [IDX_W+CNT_W-1:0] w_idx_ext;

    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_idx;
    logic [DIST_W-1:0] r_o_dist;
    logic              r_o_found;

    assign w_en       = !(r2_valid && r2_ctl.fin && r_o_valid && !i_out_ready);
    assign o_in_ready = w_en;
    assign w_accept   = i_in_valid && w_en;

    assign w_is_query = (i_kind == KIND_QUERY);
    assign w_is_cand  = (i_kind == KIND_CAND);
    assign w_is_fin   = (i_kind == KIND_FINISH);
    assign w_in_range = (r_pos < POS_W'(DIMENSIONS));
    assign w_addr     = r_pos[ADDR_W-1:0];

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if ((w_is_query || w_is_cand) && w_in_range) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (((w_is_query || w_is_cand) && i_last_element) || w_is_fin) begin
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_query && w_in_range) begin
            r_query_mem[w_addr] <= i_element_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_accept && w_is_cand && w_in_range) begin
            r1_qdata <= r_query_mem[w_addr];
        end
    end

    // stage 1: query entry and candidate element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_accept && (w_is_cand || w_is_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ctl.fin      <= w_is_fin;
            r1_ctl.last     <= i_last_element;
            r1_ctl.is_query <= i_candidate_is_query;
            r1_ctl.in_range <= w_in_range;
            r1_value        <= i_element_value;
        end
    end

    // stage 2: squared difference
    assign w_diff = $signed({r1_qdata[VAL_W-1], r1_qdata})
                  - $signed({r1_value[VAL_W-1], r1_value});
    assign w_mag  = w_diff[VAL_W] ? (VAL_W+1)'(-w_diff) : w_diff;
    assign w_sq   = w_mag[VAL_W-1:0] * w_mag[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ctl <= r1_ctl;
            r2_sq  <= w_sq;
        end
    end

    // stage 3: accumulate, compare, report
    assign w_sum     = {1'b0, r_acc} + (DIST_W+1)'(r2_sq);
    assign w_acc_new = !r2_ctl.in_range ? r_acc
                     : (w_sum[DIST_W] ? DIST_MAX : w_sum[DIST_W-1:0]);
    assign w_take    = !r2_ctl.is_query && (!r_found || (w_acc_new < r_best_dist));
    assign w_idx_ext = {{IDX_W{1'b0}}, r_best_idx};

    always_comb begin
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        n_found     = r_found;
        if (w_en && r2_valid) begin
            if (r2_ctl.fin) begin
                n_acc       = '0;
                n_cnt       = '0;
                n_best_idx  = '0;
                n_best_dist = DIST_MAX;
                n_found     = 1'b0;
            end else if (r2_ctl.last) begin
                if (w_take) begin
                    n_best_idx  = r_cnt;
                    n_best_dist = w_acc_new;
                    n_found     = 1'b1;
                end
                n_cnt = (r_cnt == CNT_W'(MAX_CANDIDATES - 1)) ? '0 : r_cnt + CNT_W'(1);
                n_acc = '0;
            end else begin
                n_acc = w_acc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_best_idx  <= '0;
            r_best_dist <= DIST_MAX;
            r_found     <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_best_idx  <= n_best_idx;
            r_best_dist <= n_best_dist;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en && r2_valid && r2_ctl.fin) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r2_valid && r2_ctl.fin) begin
            r_o_idx   <= r_found ? w_idx_ext[IDX_W-1:0] : '0;
            r_o_dist  <= r_found ? r_best_dist : '0;
            r_o_found <= r_found;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_best_index    = r_o_idx;
    assign o_best_distance = r_o_dist;
    assign o_found         = r_o_found;

    `NVS_ASSERT(a_stall_cause, !o_in_ready |-> (r_o_valid && r2_valid && r2_ctl.fin), "input stalled without a blocked finish beat")
    `NVS_ASSERT(a_not_found_zero, (o_out_valid && !o_found) |-> (o_best_distance == '0 && o_best_index == '0), "empty result carries nonzero fields")
    `NVS_ASSERT(a_pos_bound, r_pos <= POS_W'(DIMENSIONS), "element position past vector length")
    `NVS_ASSERT(a_best_idle, !r_found |-> (r_best_dist == DIST_MAX), "best distance moved without a found candidate")

endmodule

@@ test/nearest_vector_search_top_test.sv @@
// ---------------------------------------------------------------------------
// Nearest vector search testbench
// Streams query, candidate, finish and unused beats through the block under
// random idling on both channels and one long output hold-off. A local
// search tracker predicts each finish report, and the output monitor checks
// index, distance and found flag in order.
// ---------------------------------------------------------------------------
module nearest_vector_search_top_test;
    import nvs_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CALM_TAIL       = 120;
    localparam int PRESSURE_AT     = 150;
    localparam int PRESSURE_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    is_query;
    } beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
        logic              found;
    } match_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_kind = '0;
    logic signed [VAL_W-1:0] i_element_value = '0;
    logic                    i_last_element = 1'b0;
    logic                    i_candidate_is_query = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [IDX_W-1:0]        o_best_index;
    logic [DIST_W-1:0]       o_best_distance;
    logic                    o_found;

    nearest_vector_search_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_kind               (i_kind),
        .i_element_value      (i_element_value),
        .i_last_element       (i_last_element),
        .i_candidate_is_query (i_candidate_is_query),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_best_index         (o_best_index),
        .o_best_distance      (o_best_distance),
        .o_found              (o_found)
    );

    beat_t  beat_q[$];
    match_t expected_matches[$];
    beat_t  cur_beat;
    int     mismatch_count = 0;
    int     n_taken = 0;
    logic   calm = 1'b0;

    // search tracker
    logic signed [VAL_W-1:0] query_vec [DIMENSIONS];
    int unsigned             elem_pos = 0;
    longint unsigned         run_dist = 0;
    int unsigned             cand_count = 0;
    int unsigned             best_idx = 0;
    longint unsigned         best_dist = DIST_MAX;
    bit                      have_best = 1'b0;

    // stimulus-side view of the query store
    int                      gen_pos = 0;
    bit [DIMENSIONS-1:0]     q_written = '0;
    int                      n_finish_gen = 0;
    int                      qlen = 0;

    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;
    int quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic advance_search(input beat_t b);
        int              d;
        longint unsigned sum;
        match_t          m;
        case (b.kind)
            KIND_QUERY: begin
                if (elem_pos < DIMENSIONS) begin
                    query_vec[elem_pos] = b.value;
                    elem_pos++;
                end
                if (b.last) elem_pos = 0;
            end
            KIND_CAND: begin
                if (elem_pos < DIMENSIONS) begin
                    d = int'(query_vec[elem_pos]) - int'(b.value);
                    sum = run_dist + longint'(d) * longint'(d);
                    run_dist = (sum > DIST_MAX) ? DIST_MAX : sum;
                    elem_pos++;
                end
                if (b.last) begin
                    if (!b.is_query && (!have_best || run_dist < best_dist)) begin
                        best_idx = cand_count;
                        best_dist = run_dist;
                        have_best = 1'b1;
                    end
                    cand_count = (cand_count + 1) % MAX_CANDIDATES;
                    run_dist = 0;
                    elem_pos = 0;
                end
            end
            KIND_FINISH: begin
                m.index = have_best ? IDX_W'(best_idx) : '0;
                m.distance = have_best ? DIST_W'(best_dist) : '0;
                m.found = have_best;
                expected_matches.push_back(m);
                elem_pos = 0;
                run_dist = 0;
                cand_count = 0;
                best_idx = 0;
                best_dist = DIST_MAX;
                have_best = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // never let a candidate read a query entry that was not written
    task automatic emit(input logic [1:0] kind, input logic signed [VAL_W-1:0] value,
                        input logic last, input logic is_query);
        beat_t b;
        b.kind = kind;
        b.value = value;
        b.last = last;
        b.is_query = is_query;
        if (kind == KIND_CAND && gen_pos < DIMENSIONS && !q_written[gen_pos])
            b.kind = KIND_QUERY;
        case (b.kind)
            KIND_QUERY, KIND_CAND: begin
                if (gen_pos < DIMENSIONS) begin
                    if (b.kind == KIND_QUERY) q_written[gen_pos] = 1'b1;
                    gen_pos++;
                end
                if (last) gen_pos = 0;
            end
            KIND_FINISH: begin
                gen_pos = 0;
                n_finish_gen++;
            end
            default: ;
        endcase
        beat_q.push_back(b);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = VAL_W'(int'($urandom_range(0, 6)) - 3);
            1: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: v = VAL_W'($urandom());
        endcase
        return v;
    endfunction

    task automatic emit_vector(input logic [1:0] kind, input int len, input logic is_query);
        for (int i = 0; i < len; i++)
            emit(kind, pick_value(), i == len - 1,
                 (i == len - 1) ? is_query : logic'($urandom_range(0, 1)));
    endtask

    task automatic emit_random_part(input int until_items, input int until_finishes);
        int r;
        int ncand;
        int len;
        while (beat_q.size() < until_items || n_finish_gen < until_finishes) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                if (gen_pos != 0) emit(KIND_FINISH, pick_value(), 1'b0, 1'b0);
                if (qlen == 0 || $urandom_range(0, 2) == 0) begin
                    qlen = ($urandom_range(0, 19) == 0) ?
                           $urandom_range(DIMENSIONS - 2, DIMENSIONS + 4) : $urandom_range(1, 8);
                    emit_vector(KIND_QUERY, qlen, logic'($urandom_range(0, 1)));
                end
                ncand = (qlen > 16) ? $urandom_range(1, 2) : $urandom_range(0, 6);
                for (int c = 0; c < ncand; c++) begin
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, qlen + 2) : qlen;
                    emit_vector(KIND_CAND, len, $urandom_range(0, 5) == 0);
                end
                emit(KIND_FINISH, pick_value(), logic'($urandom_range(0, 1)),
                     logic'($urandom_range(0, 1)));
            end else if (r < 90) begin
                for (int n = $urandom_range(1, 6); n > 0; n--)
                    emit(2'($urandom_range(0, 3)), pick_value(), $urandom_range(0, 3) == 0,
                         logic'($urandom_range(0, 1)));
            end else begin
                for (int n = $urandom_range(1, 4); n > 0; n--)
                    emit($urandom_range(0, 1) ? KIND_CAND : KIND_QUERY, pick_value(), 1'b0,
                         logic'($urandom_range(0, 1)));
                emit(KIND_FINISH, pick_value(), 1'b0, 1'b0);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_search(cur_beat);
                n_taken <= n_taken + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (beat_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    i_in_valid <= 1'b0;
                end else begin
                    cur_beat = beat_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind <= cur_beat.kind;
                    i_element_value <= cur_beat.value;
                    i_last_element <= cur_beat.last;
                    i_candidate_is_query <= cur_beat.is_query;
                    calm <= (beat_q.size() < CALM_TAIL);
                end
            end
        end
    end

    // monitor and output backpressure
    always @(posedge i_clk) begin
        match_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch("unexpected result, index", 64'(o_best_index), '0);
                end else begin
                    want = expected_matches.pop_front();
                    if (o_best_index !== want.index)
                        report_mismatch("best_index", 64'(o_best_index), 64'(want.index));
                    if (o_best_distance !== want.distance)
                        report_mismatch("best_distance", 64'(o_best_distance),
                                        64'(want.distance));
                    if (o_found !== want.found)
                        report_mismatch("found", 64'(o_found), 64'(want.found));
                end
            end
            if (!pressure_done && n_taken >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        // directed: extremes, skipped query candidate, tie, short candidate,
        // empty finish, unused kind, finish inside a vector
        emit(KIND_QUERY, 16'h7FFF, 1'b0, 1'b0);
        emit(KIND_QUERY, 16'h8000, 1'b0, 1'b1);
        emit(KIND_QUERY, 16'h0000, 1'b0, 1'b0);
        emit(KIND_QUERY, 16'h1000, 1'b1, 1'b0);
        emit(KIND_CAND, 16'h7FFF, 1'b0, 1'b0);
        emit(KIND_CAND, 16'h8000, 1'b0, 1'b0);
        emit(KIND_CAND, 16'h0000, 1'b0, 1'b0);
        emit(KIND_CAND, 16'h1000, 1'b1, 1'b1);
        for (int n = 0; n < 2; n++) begin
            emit(KIND_CAND, 16'h8000, 1'b0, 1'b1);
            emit(KIND_CAND, 16'h7FFF, 1'b0, 1'b0);
            emit(KIND_CAND, 16'hFFFF, 1'b0, 1'b1);
            emit(KIND_CAND, 16'h0000, 1'b1, 1'b0);
        end
        emit(KIND_CAND, 16'h7FFF, 1'b1, 1'b0);
        emit(KIND_FINISH, 16'h0000, 1'b0, 1'b0);
        emit(KIND_FINISH, 16'hFFFF, 1'b1, 1'b1);
        emit(KIND_UNUSED, 16'h1234, 1'b1, 1'b0);
        emit(KIND_CAND, 16'h0001, 1'b0, 1'b0);
        emit(KIND_CAND, 16'h0002, 1'b0, 1'b0);
        emit(KIND_FINISH, 16'h0000, 1'b0, 1'b0);
        emit(KIND_CAND, 16'h4000, 1'b1, 1'b1);
        emit(KIND_FINISH, 16'h0000, 1'b0, 1'b0);
        qlen = 4;

        emit_random_part(650, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (beat_q.size() != 0 || i_in_valid || expected_matches.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
